// File: sv/fvcw_pkg.sv
// Package: types, constants and tables of the flow vector color wheel.
`timescale 1ns / 1ps
package fvcw_pkg;

  localparam int CoordBits   = 16;
  localparam int FracBits    = 8;
  localparam int CordicSteps = 13;
  localparam int WheelSize   = 55;
  localparam int AngleBits   = 16;
  localparam int ChanBits    = 8;
  localparam int CiBits      = 24;
  localparam int NegBits     = CoordBits + 1;
  localparam int CordicBits  = CoordBits + 4;
  localparam int SqBits      = 2 * NegBits + 1;
  localparam int RemBits     = 2 * FracBits + 3;
  localparam int RootBits    = FracBits + 1;
  localparam int IdxBits     = 6;
  localparam int PosBits     = AngleBits + IdxBits;
  localparam int PipeSteps   = (CordicSteps > FracBits + 1) ? CordicSteps : FracBits + 1;

  localparam logic [AngleBits-1:0] HalfTurn    = AngleBits'(1) << (AngleBits - 1);
  localparam logic [AngleBits-1:0] QuarterTurn = AngleBits'(1) << (AngleBits - 2);
  localparam logic [AngleBits-1:0] ThreeQuarter = HalfTurn + QuarterTurn;

  typedef struct packed {
    logic signed [CoordBits-1:0] flow_x;
    logic signed [CoordBits-1:0] flow_y;
    logic                        invalid;
  } flow_req_t;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
  } color_t;

  typedef struct packed {
    logic valid;
    logic fix;
    logic unit_len;
  } ctl_t;

  typedef struct packed {
    ctl_t                         ctl;
    logic signed [CordicBits-1:0] x;
    logic signed [CordicBits-1:0] y;
    logic [AngleBits-1:0]         acc;
    logic [RemBits-1:0]           rem;
    logic [RootBits-1:0]          root;
  } stage_t;

  typedef logic [WheelSize-1:0][3*ChanBits-1:0] wheel_table_t;

  function automatic logic [AngleBits-1:0] atan_turn(int idx);
    logic [AngleBits-1:0] v;
    case (idx)
      0:       v = AngleBits'(8192);
      1:       v = AngleBits'(4836);
      2:       v = AngleBits'(2555);
      3:       v = AngleBits'(1297);
      4:       v = AngleBits'(651);
      5:       v = AngleBits'(326);
      6:       v = AngleBits'(163);
      7:       v = AngleBits'(81);
      8:       v = AngleBits'(41);
      9:       v = AngleBits'(20);
      10:      v = AngleBits'(10);
      11:      v = AngleBits'(5);
      12:      v = AngleBits'(3);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic wheel_table_t build_wheel();
    wheel_table_t t;
    int r;
    int g;
    int b;
    t = '0;
    for (int i = 0; i < WheelSize; i++) begin
      if (i < 15) begin
        r = 255; g = 255 * i / 15; b = 0;
      end else if (i < 21) begin
        r = 255 - 255 * (i - 15) / 6; g = 255; b = 0;
      end else if (i < 25) begin
        r = 0; g = 255; b = 255 * (i - 21) / 4;
      end else if (i < 36) begin
        r = 0; g = 255 - 255 * (i - 25) / 11; b = 255;
      end else if (i < 49) begin
        r = 255 * (i - 36) / 13; g = 0; b = 255;
      end else begin
        r = 255; g = 0; b = 255 - 255 * (i - 49) / 6;
      end
      t[i] = {ChanBits'(r), ChanBits'(g), ChanBits'(b)};
    end
    return t;
  endfunction

  localparam wheel_table_t WheelTable = build_wheel();

endpackage

// File: sv/fvcw_step.sv
// One pipeline stage: a CORDIC vectoring step and one root bit of the length.
`timescale 1ns / 1ps
module fvcw_step #(
  parameter int Idx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fvcw_pkg::stage_t d_i,
  output fvcw_pkg::stage_t q_o
);
  import fvcw_pkg::*;

  localparam int B = (Idx <= FracBits) ? FracBits - Idx : 0;

  stage_t                  st_d;
  stage_t                  st_q;
  logic                    valid_q;
  logic signed [CordicBits-1:0] xs;
  logic signed [CordicBits-1:0] ys;
  logic [RemBits-1:0]      trial;

  always_comb begin
    st_d  = d_i;
    xs    = d_i.x >>> Idx;
    ys    = d_i.y >>> Idx;
    trial = (RemBits'(d_i.root) << (B + 1)) + (RemBits'(1) << (2 * B));
    if (Idx < CordicSteps && !d_i.ctl.fix) begin
      if (!d_i.y[CordicBits-1]) begin
        st_d.x   = d_i.x + ys;
        st_d.y   = d_i.y - xs;
        st_d.acc = d_i.acc + atan_turn(Idx);
      end else begin
        st_d.x   = d_i.x - ys;
        st_d.y   = d_i.y + xs;
        st_d.acc = d_i.acc - atan_turn(Idx);
      end
    end
    if (Idx <= FracBits && d_i.rem >= trial) begin
      st_d.rem  = d_i.rem - trial;
      st_d.root = d_i.root | (RootBits'(1) << B);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  always_comb begin
    q_o           = st_q;
    q_o.ctl.valid = valid_q;
  end

endmodule

// File: sv/fvcw_shade.sv
// Wheel lookup, hue blend and length shading over three stages.
`timescale 1ns / 1ps
module fvcw_shade (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fvcw_pkg::stage_t d_i,
  output logic             valid_o,
  output fvcw_pkg::color_t color_o
);
  import fvcw_pkg::*;

  localparam logic [CiBits-1:0] Full = CiBits'(255) << 16;
  localparam int NumBits = CiBits + RootBits;

  logic [AngleBits-1:0] p;
  logic [PosBits-1:0]   pos;
  logic [IdxBits-1:0]   k0_d, k0_q, k1_d, k1_q;
  logic [AngleBits-1:0] f_q;
  logic                 va_q, vb_q, vc_q;
  logic                 sma_q, smb_q;
  logic [RootBits-1:0]  roota_q, rootb_q;
  logic [3*ChanBits-1:0] c0, c1;
  logic [2:0][CiBits-1:0] ci_d, ci_q;
  logic [AngleBits:0]   finv;
  color_t               col_d, col_q;
  logic [2:0][NumBits-1:0] num;
  logic [2:0][CiBits+1:0]  big;

  always_comb begin
    p    = d_i.acc + HalfTurn;
    pos  = PosBits'(p) * PosBits'(WheelSize - 1);
    k0_d = pos[PosBits-1:AngleBits];
    k1_d = (k0_d == IdxBits'(WheelSize - 1)) ? '0 : k0_d + IdxBits'(1);
  end

  always_comb begin
    c0   = WheelTable[k0_q];
    c1   = WheelTable[k1_q];
    finv = (AngleBits + 1)'(1) << AngleBits;
    finv = finv - {1'b0, f_q};
    for (int ch = 0; ch < 3; ch++) begin
      ci_d[ch] = CiBits'(finv) * CiBits'(c0[(2-ch)*ChanBits +: ChanBits])
               + CiBits'(f_q) * CiBits'(c1[(2-ch)*ChanBits +: ChanBits]);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      num[ch] = (NumBits'(Full) << FracBits)
              - NumBits'(rootb_q) * NumBits'(Full - ci_q[ch]);
      big[ch] = (CiBits + 2)'(3) * (CiBits + 2)'(ci_q[ch]);
    end
    if (smb_q) begin
      col_d.red   = num[0][16+FracBits +: ChanBits];
      col_d.green = num[1][16+FracBits +: ChanBits];
      col_d.blue  = num[2][16+FracBits +: ChanBits];
    end else begin
      col_d.red   = big[0][18 +: ChanBits];
      col_d.green = big[1][18 +: ChanBits];
      col_d.blue  = big[2][18 +: ChanBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= d_i.ctl.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k0_q    <= k0_d;
    k1_q    <= k1_d;
    f_q     <= pos[AngleBits-1:0];
    sma_q   <= d_i.ctl.unit_len;
    roota_q <= d_i.root;
    ci_q    <= ci_d;
    smb_q   <= sma_q;
    rootb_q <= roota_q;
    col_q   <= col_d;
  end

  assign valid_o = vc_q;
  assign color_o = col_q;

endmodule

// File: sv/flow_vector_color_wheel_unit.sv
// Top level: flow vector to color wheel pixel, fully pipelined.
// Path: the input registers, then the step chain, then the wheel shade stages.
// Throughput: one request per clock; busy stays low, the pipeline never stalls.
// Depth is set by the 13-step CORDIC chain, run beside the length root bits.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module flow_vector_color_wheel_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  fvcw_pkg::flow_req_t flow_i,
  output logic                valid_o,
  output fvcw_pkg::color_t    color_o
);
  import fvcw_pkg::*;

  localparam int Latency = PipeSteps + 5;
  localparam logic [SqBits-1:0] UnitSq = SqBits'(1) << (2 * FracBits);

  logic                      v0_q, v1_q, v2_q;
  logic signed [NegBits-1:0] nx_d, ny_d, nx_q, ny_q;
  logic signed [CordicBits-1:0] x_d, y_d, x_q, y_q;
  logic [AngleBits-1:0]      acc_d, acc_q;
  logic                      fix_d, fix_q;
  logic [SqBits-1:0]         sqx_q, sqy_q, s;
  logic [NegBits-1:0]        ax, ay;
  stage_t                    s2_d, s2_q;
  stage_t                    chain [PipeSteps+1];

  assign busy = 1'b0;

  always_comb begin
    nx_d = flow_i.invalid ? '0 : -NegBits'(flow_i.flow_x);
    ny_d = flow_i.invalid ? '0 : -NegBits'(flow_i.flow_y);
  end

  always_comb begin
    ax    = nx_q[NegBits-1] ? NegBits'(-nx_q) : NegBits'(nx_q);
    ay    = ny_q[NegBits-1] ? NegBits'(-ny_q) : NegBits'(ny_q);
    fix_d = 1'b0;
    acc_d = '0;
    x_d   = CordicBits'(nx_q);
    y_d   = CordicBits'(ny_q);
    if (ny_q == '0) begin
      fix_d = 1'b1;
      acc_d = nx_q[NegBits-1] ? HalfTurn : '0;
    end else if (nx_q == '0) begin
      fix_d = 1'b1;
      acc_d = ny_q[NegBits-1] ? ThreeQuarter : QuarterTurn;
    end else if (nx_q[NegBits-1]) begin
      x_d   = -CordicBits'(nx_q);
      y_d   = -CordicBits'(ny_q);
      acc_d = HalfTurn;
    end
  end

  always_comb begin
    s                 = sqx_q + sqy_q;
    s2_d.ctl.valid    = v1_q;
    s2_d.ctl.fix      = fix_q;
    s2_d.ctl.unit_len = (s <= UnitSq);
    s2_d.x            = x_q;
    s2_d.y            = y_q;
    s2_d.acc          = acc_q;
    s2_d.rem          = (s <= UnitSq) ? RemBits'(s) : '0;
    s2_d.root         = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q  <= nx_d;
    ny_q  <= ny_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    fix_q <= fix_d;
    sqx_q <= SqBits'(ax) * SqBits'(ax);
    sqy_q <= SqBits'(ay) * SqBits'(ay);
    s2_q  <= s2_d;
  end

  always_comb begin
    chain[0]           = s2_q;
    chain[0].ctl.valid = v2_q;
  end

  for (genvar i = 0; i < PipeSteps; i++) begin : g_step
    fvcw_step #(
      .Idx(i)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .d_i   (chain[i]),
      .q_o   (chain[i+1])
    );
  end

  fvcw_shade u_shade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .d_i    (chain[PipeSteps]),
    .valid_o(valid_o),
    .color_o(color_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency + 1) valid_o)
    else $error("result strobe missing after request");

  a_invalid_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && flow_i.invalid) |-> ##(Latency + 1)
      (color_o.red == 8'hFF && color_o.green == 8'hFF && color_o.blue == 8'hFF))
    else $error("invalid request did not give white");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v0_q, 2))
    else $error("valid bit appeared without a request");

endmodule

// File: dv/tb.sv
// Testbench: random and directed flow vectors checked against a color wheel predictor.
`timescale 1ns / 1ps
module tb;
  import fvcw_pkg::*;

  class color_scoreboard;
    color_t expected_q[$];
    int     errors;

    function automatic logic [7:0] wheel_chan(int idx, int ch);
      int r;
      int g;
      int b;
      if (idx < 15) begin
        r = 255; g = 255 * idx / 15; b = 0;
      end else if (idx < 21) begin
        r = 255 - 255 * (idx - 15) / 6; g = 255; b = 0;
      end else if (idx < 25) begin
        r = 0; g = 255; b = 255 * (idx - 21) / 4;
      end else if (idx < 36) begin
        r = 0; g = 255 - 255 * (idx - 25) / 11; b = 255;
      end else if (idx < 49) begin
        r = 255 * (idx - 36) / 13; g = 0; b = 255;
      end else begin
        r = 255; g = 0; b = 255 - 255 * (idx - 49) / 6;
      end
      return (ch == 0) ? r[7:0] : ((ch == 1) ? g[7:0] : b[7:0]);
    endfunction

    function automatic logic [15:0] vector_angle(longint x, longint y);
      logic [15:0] acc;
      longint xs;
      longint ys;
      int turns[13];
      turns = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3};
      acc = 0;
      if (y == 0) return (x >= 0) ? 16'd0 : 16'd32768;
      if (x == 0) return (y > 0) ? 16'd16384 : 16'd49152;
      if (x < 0) begin
        x = -x; y = -y; acc = 16'd32768;
      end
      for (int i = 0; i < 13; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; acc = acc + 16'(turns[i]);
        end else begin
          x = x - ys; y = y + xs; acc = acc - 16'(turns[i]);
        end
      end
      return acc;
    endfunction

    function automatic color_t predict_color(flow_req_t req);
      longint x;
      longint y;
      longint s;
      longint n;
      longint pos;
      longint ci;
      longint v;
      longint num;
      logic [15:0] p;
      int k0;
      int k1;
      longint f;
      logic [7:0] ch_val[3];
      x = req.invalid ? 0 : longint'(req.flow_x);
      y = req.invalid ? 0 : longint'(req.flow_y);
      x = -x; y = -y;
      s = x * x + y * y;
      n = 0;
      if (s <= 65536)
        while ((n + 1) * (n + 1) <= s) n++;
      p = vector_angle(x, y) + 16'd32768;
      pos = longint'(p) * 54;
      k0 = int'(pos >> 16);
      k1 = (k0 + 1 >= 55) ? 0 : k0 + 1;
      f = pos & 64'hFFFF;
      for (int ch = 0; ch < 3; ch++) begin
        ci = (65536 - f) * wheel_chan(k0, ch) + f * wheel_chan(k1, ch);
        if (s <= 65536) begin
          num = (longint'(255) << 24) - n * ((longint'(255) << 16) - ci);
          v = num >> 24;
        end else begin
          v = (3 * ci) >> 18;
        end
        ch_val[ch] = v[7:0];
      end
      return '{red: ch_val[0], green: ch_val[1], blue: ch_val[2]};
    endfunction

    function void note_request(flow_req_t req);
      expected_q.push_back(predict_color(req));
    endfunction

    function void check_color(color_t got);
      color_t exp_c;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected color %h", $time, got);
        errors++;
        return;
      end
      exp_c = expected_q[0];
      expected_q.delete(0);
      if (got.red !== exp_c.red)
        $display("%0t: red expected %0d actual %0d", $time, exp_c.red, got.red);
      if (got.green !== exp_c.green)
        $display("%0t: green expected %0d actual %0d", $time, exp_c.green, got.green);
      if (got.blue !== exp_c.blue)
        $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue, got.blue);
      if (got !== exp_c) errors++;
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  flow_req_t flow_i;
  logic      valid_o;
  color_t    color_o;
  int        idle_pct;
  int        quiet_cycles;
  color_scoreboard sb;

  flow_vector_color_wheel_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .flow_i (flow_i),
    .valid_o(valid_o),
    .color_o(color_o)
  );

  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_color(color_o);
    if (rst_ni && ((start && !busy) || valid_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(logic signed [15:0] fx, logic signed [15:0] fy, logic inv);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    flow_i <= '{flow_x: fx, flow_y: fy, invalid: inv};
    do @(posedge clk_i); while (busy);
    sb.note_request(flow_i);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    case ($urandom_range(3))
      0: begin
        fx = $signed(16'($urandom_range(512))) - 16'sd256;
        fy = $signed(16'($urandom_range(512))) - 16'sd256;
      end
      1: begin
        fx = $signed(16'($urandom_range(4096))) - 16'sd2048;
        fy = $signed(16'($urandom_range(4096))) - 16'sd2048;
      end
      default: begin
        fx = 16'($urandom);
        fy = 16'($urandom);
      end
    endcase
    send_request(fx, fy, ($urandom_range(15) == 0));
  endtask

  initial begin
    sb = new();
    start = 1'b0;
    flow_i = '0;
    rst_ni = 1'b0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_request(16'sd0, 16'sd0, 1'b0);
    send_request(16'sd1234, -16'sd77, 1'b1);
    send_request(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_request(-16'sd32768, -16'sd32768, 1'b0);
    send_request(-16'sd32768, 16'sh7FFF, 1'b0);
    send_request(16'sh7FFF, -16'sd32768, 1'b0);
    send_request(16'sd256, 16'sd0, 1'b0);
    send_request(-16'sd256, 16'sd0, 1'b0);
    send_request(16'sd0, 16'sd256, 1'b0);
    send_request(16'sd0, -16'sd256, 1'b0);
    send_request(16'sd181, 16'sd181, 1'b0);
    send_request(16'sd181, 16'sd182, 1'b0);
    send_request(16'sd257, 16'sd0, 1'b0);
    send_request(16'sd1, 16'sd0, 1'b0);
    send_request(-16'sd1, -16'sd1, 1'b0);
    send_request(16'sd128, -16'sd100, 1'b0);
    send_request(-16'sd300, 16'sd1, 1'b0);
    send_request(16'sd2, -16'sd1, 1'b0);
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 33 : ((phase == 1) ? 61 : 0);
      for (int i = 0; i < 480; i++) send_random();
    end
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
